@@ rtl/tccs_pkg.sv @@
// ============================================================================
// tccs_pkg
// Shared types, constants and helpers for the text console engine.
// ============================================================================
package tccs_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int LOC_W      = 11;
    localparam int LOC_CALC_W = (ADDR_W > LOC_W) ? ADDR_W : LOC_W;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [3:0]  bg_color;
        logic [3:0]  fg_color;
        logic [10:0] cell_index;
    } tccs_in_t;

    typedef struct packed {
        logic [10:0] cursor_location;
        logic [15:0] read_data;
    } tccs_out_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scroll;
        logic fill;
        logic cnt_zero;
        logic result_load;
    } tccs_cmd_t;

    typedef struct packed {
        logic scroll_req;
        logic clear_req;
        logic scroll_last;
        logic fill_last;
        logic out_busy;
    } tccs_status_t;

    function automatic logic [LOC_CALC_W-1:0] cell_loc(
        logic [ROW_W-1:0] r,
        logic [COL_W-1:0] c
    );
        return LOC_CALC_W'(r) * LOC_CALC_W'(COLUMNS) + LOC_CALC_W'(c);
    endfunction

endpackage

@@ rtl/tccs_ctrl.sv @@
// ============================================================================
// tccs_ctrl
// Sequencer: intake, command execution, scroll and fill sweeps, result hand-off.
// ============================================================================
module tccs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tccs_pkg::tccs_status_t st,
    output tccs_pkg::tccs_cmd_t   cmd
);
    import tccs_pkg::*;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.fill = 1'b1;
                if (st.fill_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (st.scroll_req)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = S_SCROLL;
                end
                else if (st.clear_req)
                begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = S_FILL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCROLL:
            begin
                cmd.scroll = 1'b1;
                if (st.scroll_last)
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (st.fill_last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

@@ rtl/tccs_dp.sv @@
// ============================================================================
// tccs_dp
// Datapath: screen memory, cursor, sweep counter, item and result registers.
// ============================================================================
module tccs_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tccs_pkg::tccs_in_t     in_data,
    input  tccs_pkg::tccs_cmd_t    cmd,
    output tccs_pkg::tccs_status_t st,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tccs_pkg::tccs_out_t    out_data
);
    import tccs_pkg::*;

    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_data_reg;
    tccs_in_t          item_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic              rd_hit_reg;
    logic              out_valid_reg;
    tccs_out_t         out_data_reg;

    logic [COL_W:0]    col_a;
    logic [COL_W:0]    col_b;
    logic [ROW_W:0]    row_a;
    logic [ROW_W:0]    row_b;
    logic              put_wr;
    logic              is_put;
    logic              is_read;
    logic              is_clear;
    logic              rd_in_range;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign is_put      = (item_reg.cmd == CMD_PUT);
    assign is_read     = (item_reg.cmd == CMD_READ);
    assign is_clear    = (item_reg.cmd == CMD_CLEAR);
    assign rd_in_range = (32'(item_reg.cell_index) < CELLS);

    // cursor update for a put
    always_comb
    begin
        col_a  = {1'b0, col_reg};
        row_a  = {1'b0, row_reg};
        put_wr = 1'b0;
        priority if (item_reg.char_code == CH_BS)
        begin
            if (col_reg != '0)
                col_a = col_a - 1'b1;
        end
        else if (item_reg.char_code == CH_TAB)
        begin
            col_a = (col_a + (COL_W+1)'(8)) & ~((COL_W+1)'(7));
        end
        else if (item_reg.char_code == CH_CR)
        begin
            col_a = '0;
        end
        else if (item_reg.char_code == CH_LF)
        begin
            col_a = '0;
            row_a = row_a + 1'b1;
        end
        else if (item_reg.char_code >= CH_SPACE && item_reg.char_code <= CH_DEL)
        begin
            put_wr = 1'b1;
            col_a  = col_a + 1'b1;
        end
        else
        begin
            col_a = {1'b0, col_reg};
        end

        if (col_a >= (COL_W+1)'(COLUMNS))
        begin
            col_b = '0;
            row_b = row_a + 1'b1;
        end
        else
        begin
            col_b = col_a;
            row_b = row_a;
        end
    end

    assign st.scroll_req  = is_put && (row_b >= (ROW_W+1)'(ROWS));
    assign st.clear_req   = is_clear;
    assign st.scroll_last = (cnt_reg == ADDR_W'(CELLS - COLUMNS));
    assign st.fill_last   = (cnt_reg == ADDR_W'(CELLS - 1));
    assign st.out_busy    = out_valid_reg && !out_ready;

    // memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = BLANK_CELL;
        rd_en   = 1'b0;
        rd_addr = cnt_reg + ADDR_W'(COLUMNS);
        if (cmd.exec && is_put && put_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cell_loc(row_reg, col_reg));
            wr_data = {item_reg.bg_color, item_reg.fg_color, item_reg.char_code};
        end
        else if (cmd.scroll)
        begin
            wr_en   = (cnt_reg != '0);
            wr_addr = cnt_reg - 1'b1;
            wr_data = rd_data_reg;
        end
        else if (cmd.fill)
        begin
            wr_en = 1'b1;
        end

        if (cmd.exec && is_read && rd_in_range)
        begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(item_reg.cell_index);
        end
        else if (cmd.scroll && !st.scroll_last)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec && is_put)
        begin
            col_next = COL_W'(col_b);
            if (st.scroll_req)
                row_next = ROW_W'(ROWS - 1);
            else
                row_next = ROW_W'(row_b);
        end
        else if (cmd.exec && is_clear)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_zero)
            cnt_next = '0;
        else if ((cmd.scroll && !st.scroll_last) || (cmd.fill && !st.fill_last))
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (cmd.result_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.exec)
            rd_hit_reg <= is_read && rd_in_range;
        if (cmd.result_load)
        begin
            out_data_reg.cursor_location <= LOC_W'(cell_loc(row_reg, col_reg));
            out_data_reg.read_data       <= rd_hit_reg ? rd_data_reg : 16'h0000;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/text_console_cursor_scroll.sv @@
// ============================================================================
// text_console_cursor_scroll
// Text console engine over a screen of 16-bit cells with cursor and scroll.
// ============================================================================
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | in_data  (cmd, char, colors, cell index)
//  out      | out_valid / out_ready| out_data (cursor location, read data)
//
//  One item at a time. Put, read and unused commands: the item is registered,
//  executed, then its result is registered in a finish step that waits while
//  a previous result still stalls on out_ready. A scroll adds a copy sweep plus
//  last-row fill, a clear adds a whole-screen fill; both are screen memory sweeps.
//  After reset a clearing pass fills the screen with blank cells, in_ready low.
//  A new item may transfer while the previous result waits on out_ready.
// ============================================================================
module text_console_cursor_scroll (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tccs_pkg::tccs_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tccs_pkg::tccs_out_t out_data
);
    import tccs_pkg::*;

    tccs_cmd_t    cmd;
    tccs_status_t st;

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    tccs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/tccs_checker.sv @@
// ============================================================================
// tccs_checker
// Port-level checks for the text console engine.
// ============================================================================
module tccs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input tccs_pkg::tccs_out_t out_data
);
    import tccs_pkg::*;

    // one item in flight: intake closes right after a transfer
    a_intake_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high the cycle after an input transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.cursor_location) < CELLS))
        else $error("cursor location beyond screen");

    // a result never appears in the cycle right after an intake transfer
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result without execution time");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (.*);
